[rtl/xcfd_pkg.sv]
// shared types and constants for the xor checked frame deframer
package xcfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned INDEX_W = 5;

  // register byte addresses on the config port
  localparam logic [1:0] REG_START_BYTE_ADDR = 2'd0;
  localparam logic [7:0] START_BYTE_RESET    = 8'hAA;

  typedef enum logic [2:0] {
    ST_START,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_CHECK,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic clr_xor;
    logic ld_cmd;
    logic ld_len;
    logic wr_data;
    logic emit_clr;
    logic rd_req;
    logic ld_out;
    logic emit_inc;
  } ctl_t;

  typedef struct packed {
    logic start_hit;
    logic len_zero;
    logic data_done;
    logic check_ok;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

[rtl/xcfd_ram.sv]
// generic single write port ram with registered read
module xcfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/xcfd_ctrl.sv]
// frame controller state machine
module xcfd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  xcfd_pkg::sts_t sts,
  output xcfd_pkg::ctl_t ctl
);

  import xcfd_pkg::*;

  state_t state;
  state_t state_next;
  logic   in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      ST_START, ST_CMD, ST_LEN, ST_DATA, ST_CHECK: in_ready = 1'b1;
      default:                                      in_ready = 1'b0;
    endcase
  end

  assign in_fire = in_valid & in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_START: begin
        if (in_fire && sts.start_hit) state_next = ST_CMD;
      end
      ST_CMD: begin
        if (in_fire) state_next = ST_LEN;
      end
      ST_LEN: begin
        if (in_fire) state_next = sts.len_zero ? ST_CHECK : ST_DATA;
      end
      ST_DATA: begin
        if (in_fire && sts.data_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (in_fire) state_next = sts.check_ok ? ST_READ : ST_START;
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) state_next = sts.emit_last ? ST_START : ST_READ;
      end
      default: begin
        state_next = ST_START;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      ST_START: begin
        ctl.clr_xor = in_fire & sts.start_hit;
      end
      ST_CMD: begin
        ctl.ld_cmd = in_fire;
      end
      ST_LEN: begin
        ctl.ld_len = in_fire;
      end
      ST_DATA: begin
        ctl.wr_data = in_fire;
      end
      ST_CHECK: begin
        ctl.emit_clr = in_fire;
      end
      ST_READ: begin
        ctl.rd_req = 1'b1;
      end
      ST_LOAD: begin
        ctl.ld_out   = sts.out_free;
        ctl.emit_inc = sts.out_free & ~sts.emit_last;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

[rtl/xcfd_dp.sv]
// frame datapath: header registers, checksum, payload store and result register
module xcfd_dp #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  xcfd_pkg::ctl_t                   ctl,
  output xcfd_pkg::sts_t                   sts,
  input  logic [xcfd_pkg::BYTE_W-1:0]      start_byte,
  input  logic [xcfd_pkg::BYTE_W-1:0]      rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [xcfd_pkg::BYTE_W-1:0]      command,
  output logic [xcfd_pkg::LEN_W-1:0]       length,
  output logic [xcfd_pkg::INDEX_W-1:0]     byte_index,
  output logic [xcfd_pkg::BYTE_W-1:0]      payload_byte,
  output logic                             has_payload,
  output logic                             last
);

  import xcfd_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

  logic [BYTE_W-1:0] held_command;
  logic [BYTE_W-1:0] held_length;
  logic [BYTE_W-1:0] fill_index;
  logic [BYTE_W-1:0] running_xor;
  logic [AW-1:0]     emit_idx;
  logic [BYTE_W-1:0] emit_idx_w;
  logic [BYTE_W-1:0] rd_data;
  logic              store_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_command <= '0;
      held_length  <= '0;
      fill_index   <= '0;
      running_xor  <= '0;
      emit_idx     <= '0;
    end else begin
      if (ctl.clr_xor) begin
        running_xor <= '0;
      end else if (ctl.ld_cmd || ctl.ld_len || ctl.wr_data) begin
        running_xor <= running_xor ^ rx_byte;
      end
      if (ctl.ld_cmd) begin
        held_command <= rx_byte;
      end
      if (ctl.ld_len) begin
        held_length <= rx_byte;
        fill_index  <= '0;
      end else if (ctl.wr_data) begin
        fill_index <= fill_index + 8'd1;
      end
      if (ctl.emit_clr) begin
        emit_idx <= '0;
      end else if (ctl.emit_inc) begin
        emit_idx <= emit_idx + AW'(1);
      end
    end
  end

  // bytes past the store capacity are counted but not kept
  assign store_wr = ctl.wr_data & (fill_index < MAX_LEN);

  xcfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (fill_index[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (ctl.rd_req),
    .rd_addr (emit_idx),
    .rd_data (rd_data)
  );

  assign emit_idx_w = BYTE_W'(emit_idx);

  assign sts.start_hit = (rx_byte == start_byte);
  assign sts.len_zero  = (rx_byte == '0);
  assign sts.data_done = ((fill_index + 8'd1) >= held_length);
  assign sts.check_ok  = (rx_byte == running_xor) && (held_length <= MAX_LEN);
  assign sts.out_free  = ~out_valid | out_ready;
  assign sts.emit_last = (held_length == '0) || ((emit_idx_w + 8'd1) == held_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      command      <= held_command;
      length       <= held_length[LEN_W-1:0];
      byte_index   <= emit_idx_w[INDEX_W-1:0];
      payload_byte <= (held_length == '0) ? '0 : rd_data;
      has_payload  <= (held_length != '0);
      last         <= sts.emit_last;
    end
  end

endmodule

[rtl/xor_checked_frame_deframer.sv]
// xor checked frame deframer top level
// takes one rx beat per cycle while hunting or collecting a frame
// on a good check beat the results follow, one per payload byte (one for an empty
// payload), each read from the payload store and loaded once the output is free
// no rx beat is taken while a frame's results are being read out
// synchronous reset: hunting for the start byte, start byte register back to 0xaa
module xor_checked_frame_deframer #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [xcfd_pkg::BYTE_W-1:0]  rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [xcfd_pkg::BYTE_W-1:0]  command,
  output logic [xcfd_pkg::LEN_W-1:0]   length,
  output logic [xcfd_pkg::INDEX_W-1:0] byte_index,
  output logic [xcfd_pkg::BYTE_W-1:0]  payload_byte,
  output logic                         has_payload,
  output logic                         last
);

  import xcfd_pkg::*;

  logic [BYTE_W-1:0] start_byte;
  logic              reg_wr;
  ctl_t              ctl;
  sts_t              sts;

  assign reg_wr = psel & penable & pwrite & pready & (paddr == REG_START_BYTE_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
    end else if (reg_wr) begin
      start_byte <= pwdata[BYTE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = 32'(start_byte);

  xcfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  xcfd_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .start_byte   (start_byte),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .command      (command),
    .length       (length),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .has_payload  (has_payload),
    .last         (last)
  );

endmodule
